// ----- hw/rtl/blowfish_block_cipher_assert.svh -----
// assertion macros shared by the cipher core rtl
// expects aclk and aresetn in the scope of each use
`ifndef BLOWFISH_BLOCK_CIPHER_ASSERT_SVH
`define BLOWFISH_BLOCK_CIPHER_ASSERT_SVH

// same-cycle implication
`define BF_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("bf assertion failed");

// next-cycle implication
`define BF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("bf assertion failed");

`endif

// ----- hw/rtl/bf_pkg.sv -----
// types, codes and the round function of the blowfish cipher core
// no dependencies
`timescale 1ns / 1ps

package bf_pkg;

    localparam int ROUNDS_DEF = 16;
    localparam int SBOX_COUNT = 4;
    localparam int SBOX_DEPTH = 256;
    localparam int SBOX_AW    = 8;
    localparam int WORD_W     = 32;
    localparam int BLOCK_W    = 64;
    localparam int INDEX_W    = 10;
    localparam int KIND_W     = 2;
    localparam int S_DATA_W   = 112;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 64;

    typedef enum logic [KIND_W-1:0] {
        KIND_LOAD_P  = 2'd0,
        KIND_LOAD_S  = 2'd1,
        KIND_ENCRYPT = 2'd2,
        KIND_DECRYPT = 2'd3
    } kind_t;

    localparam logic [CFG_IDX_W-1:0] CFG_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IV   = 2'd1;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } state_t;

    function automatic logic [WORD_W-1:0] feistel(
        input logic [WORD_W-1:0] a,
        input logic [WORD_W-1:0] b,
        input logic [WORD_W-1:0] c,
        input logic [WORD_W-1:0] d
    );
        feistel = ((a + b) ^ c) + d;
    endfunction

endpackage

// ----- hw/rtl/blowfish_block_cipher.sv -----
// Blowfish cipher core: 64-bit blocks, ECB and CBC, subkeys loaded by items.
// A cipher item runs in steps: one to take the block and launch the first
// S-box lookup, then one per round, sixteen by default, each waiting on the
// registered read of the four 256-entry S-box RAMs. s_axis_tready is low
// while a block is in flight. Load items give no result. The result sits in
// an output register, so the next item may be taken while it waits; a block
// finishing behind a result that is still waiting holds in its last round.
// Depends on bf_pkg, bf_ram and blowfish_block_cipher_assert.svh.
`timescale 1ns / 1ps

`include "blowfish_block_cipher_assert.svh"

module blowfish_block_cipher
    import bf_pkg::*;
#(
    parameter int ROUNDS = ROUNDS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // configuration writes
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    // input items
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [S_DATA_W-1:0]   s_axis_tdata,  // entry_index, entry_word, block_in, pad
    input  logic [KIND_W-1:0]     s_axis_tuser,  // kind
    // result items
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [BLOCK_W-1:0]    m_axis_tdata   // block_out
);

    localparam int P_COUNT = ROUNDS + 2;
    localparam int PW      = $clog2(P_COUNT);
    localparam int RW      = $clog2(ROUNDS);

    // input fields
    logic [INDEX_W-1:0] entry_index;
    logic [WORD_W-1:0]  entry_word;
    logic [BLOCK_W-1:0] block_in;
    kind_t              kind;

    assign entry_index = s_axis_tdata[INDEX_W-1:0];
    assign entry_word  = s_axis_tdata[INDEX_W+WORD_W-1:INDEX_W];
    assign block_in    = s_axis_tdata[INDEX_W+WORD_W+BLOCK_W-1:INDEX_W+WORD_W];
    assign kind        = kind_t'(s_axis_tuser);

    state_t             state_reg, state_next;
    logic [RW-1:0]      round_reg;
    logic               dec_reg;
    logic               upd_enc_reg;
    logic [WORD_W-1:0]  l_reg;
    logic [WORD_W-1:0]  r_reg;
    logic [BLOCK_W-1:0] mask_reg;
    logic               mode_reg;
    logic [BLOCK_W-1:0] enc_chain_reg;
    logic [BLOCK_W-1:0] dec_chain_reg;
    logic               m_valid_reg;
    logic [BLOCK_W-1:0] m_data_reg;
    logic [WORD_W-1:0]  p_reg [P_COUNT];

    logic               in_acc;
    logic               cipher_acc;
    logic               acc_dec;
    logic               last_round;
    logic               stall;
    logic               finish;
    logic [BLOCK_W-1:0] blk_x;
    logic [PW-1:0]      k_first;
    logic [PW-1:0]      k_next;
    logic [WORD_W-1:0]  f_val;
    logic [WORD_W-1:0]  r_mix;
    logic [WORD_W-1:0]  l_next;
    logic [WORD_W-1:0]  p_a;
    logic [WORD_W-1:0]  p_b;
    logic [BLOCK_W-1:0] result;
    logic               ram_re;
    logic [WORD_W-1:0]  sdata [SBOX_COUNT];

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign cfg_ready     = 1'b1;
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign cipher_acc    = in_acc && (kind == KIND_ENCRYPT || kind == KIND_DECRYPT);
    assign acc_dec       = (kind == KIND_DECRYPT);

    assign last_round = (round_reg == RW'(ROUNDS - 1));
    assign stall      = (state_reg == ST_RUN) && last_round && m_valid_reg && !m_axis_tready;
    assign finish     = (state_reg == ST_RUN) && last_round && !stall;

    // cbc chaining of the incoming block and first subkey
    assign blk_x   = (kind == KIND_ENCRYPT && mode_reg) ? (block_in ^ enc_chain_reg) : block_in;
    assign k_first = acc_dec ? PW'(P_COUNT - 1) : '0;
    assign k_next  = dec_reg ? (PW'(ROUNDS) - PW'(round_reg)) : (PW'(round_reg) + PW'(1));

    // round datapath
    assign f_val = feistel(sdata[0], sdata[1], sdata[2], sdata[3]);
    assign r_mix = r_reg ^ f_val;
    assign p_a   = dec_reg ? p_reg[1] : p_reg[ROUNDS];
    assign p_b   = dec_reg ? p_reg[0] : p_reg[ROUNDS + 1];
    assign result = {l_reg ^ p_b, r_mix ^ p_a} ^ mask_reg;

    always_comb begin
        if (state_reg == ST_IDLE) begin
            l_next = blk_x[BLOCK_W-1:WORD_W] ^ p_reg[k_first];
        end else begin
            l_next = r_mix ^ p_reg[k_next];
        end
    end

    assign ram_re = cipher_acc || ((state_reg == ST_RUN) && !stall);

    // four S-box rams, one lookup byte each, most significant byte to box 0
    for (genvar b = 0; b < SBOX_COUNT; b++) begin : g_sbox
        logic we;
        assign we = in_acc && (kind == KIND_LOAD_S)
                    && (entry_index[INDEX_W-1:SBOX_AW] == (INDEX_W - SBOX_AW)'(b));
        bf_ram #(
            .WIDTH (WORD_W),
            .DEPTH (SBOX_DEPTH)
        ) u_sbox (
            .aclk  (aclk),
            .we    (we),
            .waddr (entry_index[SBOX_AW-1:0]),
            .wdata (entry_word),
            .re    (ram_re),
            .raddr (l_next[WORD_W-1-SBOX_AW*b -: SBOX_AW]),
            .rdata (sdata[b])
        );
    end

    // sequencer
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (cipher_acc) begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                if (finish) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            round_reg     <= '0;
            m_valid_reg   <= 1'b0;
            mode_reg      <= 1'b0;
            enc_chain_reg <= '0;
            dec_chain_reg <= '0;
            upd_enc_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;

            if (cfg_valid && cfg_ready) begin
                if (cfg_index == CFG_MODE) begin
                    mode_reg <= cfg_data[0];
                end else if (cfg_index == CFG_IV) begin
                    enc_chain_reg <= cfg_data;
                    dec_chain_reg <= cfg_data;
                end
            end

            if (cipher_acc) begin
                round_reg   <= '0;
                upd_enc_reg <= mode_reg && !acc_dec;
                if (mode_reg && acc_dec) begin
                    dec_chain_reg <= block_in;
                end
            end else if ((state_reg == ST_RUN) && !stall && !last_round) begin
                round_reg <= round_reg + RW'(1);
            end

            if (finish) begin
                m_valid_reg <= 1'b1;
                if (upd_enc_reg) begin
                    enc_chain_reg <= result;
                end
            end else if (m_axis_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        if (in_acc && kind == KIND_LOAD_P && entry_index < INDEX_W'(P_COUNT)) begin
            p_reg[entry_index[PW-1:0]] <= entry_word;
        end
        if (cipher_acc) begin
            dec_reg  <= acc_dec;
            l_reg    <= l_next;
            r_reg    <= blk_x[WORD_W-1:0];
            mask_reg <= (mode_reg && acc_dec) ? dec_chain_reg : '0;
        end else if ((state_reg == ST_RUN) && !stall && !last_round) begin
            l_reg <= l_next;
            r_reg <= l_reg;
        end
        if (finish) begin
            m_data_reg <= result;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    `BF_ASSERT_NEXT(a_cipher_starts, cipher_acc, state_reg == ST_RUN && round_reg == '0)
    `BF_ASSERT_NEXT(a_finish_delivers, finish, m_valid_reg && state_reg == ST_IDLE)
    `BF_ASSERT_IMPL(a_round_in_range, state_reg == ST_RUN, round_reg <= RW'(ROUNDS - 1))
    `BF_ASSERT_NEXT(a_iv_loads_chains, cfg_valid && cfg_index == CFG_IV,
        enc_chain_reg == $past(cfg_data) && dec_chain_reg == $past(cfg_data))

endmodule

// ----- hw/rtl/bf_ram.sv -----
// generic simple dual-port ram, one write and one registered read port
// no dependencies
`timescale 1ns / 1ps

module bf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- verif/blowfish_block_cipher_test.sv -----
`timescale 1ns / 1ps
// self-checking testbench for blowfish_block_cipher: subkey loads, ecb and cbc blocks
// checked against a scoreboard that keeps its own subkeys and chains; needs bf_pkg and the rtl

localparam int BF_P_WORDS = bf_pkg::ROUNDS_DEF + 2;

class cipher_scoreboard;
    logic [31:0] p_keys [BF_P_WORDS];
    logic [31:0] sbox_words [1024];
    logic [63:0] enc_chain;
    logic [63:0] dec_chain;
    logic        cbc_on;
    logic [63:0] expected_blocks [$];
    logic [63:0] enc_log [$];
    int          errors;
    int          blocks_checked;
    int          loads_seen;
    int          config_writes;

    function new();
        foreach (p_keys[i]) p_keys[i] = '0;
        foreach (sbox_words[i]) sbox_words[i] = '0;
        enc_chain      = '0;
        dec_chain      = '0;
        cbc_on         = 1'b0;
        errors         = 0;
        blocks_checked = 0;
        loads_seen     = 0;
        config_writes  = 0;
    endfunction

    function logic [31:0] round_f(logic [31:0] x);
        logic [31:0] a, b, c, d;
        a = sbox_words[{2'd0, x[31:24]}];
        b = sbox_words[{2'd1, x[23:16]}];
        c = sbox_words[{2'd2, x[15:8]}];
        d = sbox_words[{2'd3, x[7:0]}];
        return ((a + b) ^ c) + d;
    endfunction

    function logic [63:0] blowfish_rounds(logic [63:0] blk, logic decrypting);
        logic [31:0] left, right, tmp;
        int k;
        left  = blk[63:32];
        right = blk[31:0];
        for (int i = 0; i < bf_pkg::ROUNDS_DEF; i++) begin
            k = decrypting ? (BF_P_WORDS - 1 - i) : i;
            left  = left ^ p_keys[k];
            right = right ^ round_f(left);
            tmp   = left;
            left  = right;
            right = tmp;
        end
        tmp   = left;
        left  = right;
        right = tmp;
        right = right ^ p_keys[decrypting ? 1 : bf_pkg::ROUNDS_DEF];
        left  = left ^ p_keys[decrypting ? 0 : bf_pkg::ROUNDS_DEF + 1];
        return {left, right};
    endfunction

    function void note_config(logic [bf_pkg::CFG_IDX_W-1:0] idx, logic [63:0] data);
        config_writes++;
        if (idx == bf_pkg::CFG_MODE) begin
            cbc_on = data[0];
        end else if (idx == bf_pkg::CFG_IV) begin
            enc_chain = data;
            dec_chain = data;
        end
    endfunction

    function void note_item(bf_pkg::kind_t kind, logic [9:0] idx, logic [31:0] word,
                            logic [63:0] blk);
        logic [63:0] res;
        case (kind)
            bf_pkg::KIND_LOAD_P: begin
                if (idx < BF_P_WORDS) p_keys[idx] = word;
                loads_seen++;
            end
            bf_pkg::KIND_LOAD_S: begin
                sbox_words[idx] = word;
                loads_seen++;
            end
            bf_pkg::KIND_ENCRYPT: begin
                if (cbc_on) begin
                    res       = blowfish_rounds(blk ^ enc_chain, 1'b0);
                    enc_chain = res;
                end else begin
                    res = blowfish_rounds(blk, 1'b0);
                end
                enc_log.push_back(res);
                expected_blocks.push_back(res);
            end
            default: begin
                res = blowfish_rounds(blk, 1'b1);
                if (cbc_on) begin
                    res       = res ^ dec_chain;
                    dec_chain = blk;
                end
                expected_blocks.push_back(res);
            end
        endcase
    endfunction

    function void check_result(logic [63:0] actual);
        logic [63:0] want;
        if (expected_blocks.size() == 0) begin
            $display("%0t: unexpected block_out %h with nothing expected", $time, actual);
            errors++;
            return;
        end
        want = expected_blocks.pop_front();
        blocks_checked++;
        if (actual !== want) begin
            $display("%0t: block_out mismatch, expected %h, actual %h", $time, want, actual);
            errors++;
        end
    endfunction

    function int pending();
        return expected_blocks.size();
    endfunction
endclass

module blowfish_block_cipher_test;
    import bf_pkg::*;

    localparam int SETTLE_CYCLES = 40;
    localparam int QUIET_LIMIT   = 2000;
    localparam int HOLD_CYCLES   = 300;
    localparam int PHASES        = 7;
    localparam int PHASE_ITEMS   = 40;
    localparam int ROUND_TRIP    = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [S_DATA_W-1:0]   s_axis_tdata;
    logic [KIND_W-1:0]     s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [BLOCK_W-1:0]    m_axis_tdata;

    logic steady       = 1'b0;
    logic hold_request = 1'b0;
    int   quiet_cycles = 0;

    cipher_scoreboard sb = new();

    blowfish_block_cipher dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    function automatic logic [BLOCK_W-1:0] rand_block();
        int r;
        r = $urandom_range(15);
        if (r == 0) return '0;
        if (r == 1) return '1;
        return {$urandom(), $urandom()};
    endfunction

    task automatic send_item(kind_t kind, logic [INDEX_W-1:0] idx, logic [WORD_W-1:0] word,
                             logic [BLOCK_W-1:0] blk);
        while (!steady && $urandom_range(99) < 22) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {{(S_DATA_W - BLOCK_W - WORD_W - INDEX_W){1'b0}}, blk, word, idx};
        do @(posedge aclk); while (!s_axis_tready);
    endtask

    task automatic send_cipher(kind_t kind, logic [BLOCK_W-1:0] blk);
        send_item(kind, INDEX_W'($urandom_range(1023)), $urandom(), blk);
    endtask

    // drain all results, then let any trailing load finish
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        do @(posedge aclk); while (sb.pending() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready) sb.note_config(cfg_index, cfg_data);
            if (s_axis_tvalid && s_axis_tready) begin
                sb.note_item(kind_t'(s_axis_tuser), s_axis_tdata[INDEX_W-1:0],
                             s_axis_tdata[INDEX_W +: WORD_W],
                             s_axis_tdata[INDEX_W + WORD_W +: BLOCK_W]);
            end
            if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no item moved for %0d cycles", $time, QUIET_LIMIT);
            $display("FAILURE");
            $finish;
        end
    end

    // result side, with one long hold-off on request
    initial begin
        m_axis_tready <= 1'b0;
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end
            m_axis_tready <= steady || ($urandom_range(99) >= 22);
            @(posedge aclk);
        end
    end

    initial begin
        int                 pick;
        logic               cbc_phase;
        logic [BLOCK_W-1:0] blk;
        logic [BLOCK_W-1:0] cfg_word;
        logic [BLOCK_W-1:0] trip [$];

        aresetn       <= 1'b0;
        cfg_valid     <= 1'b0;
        cfg_index     <= CFG_MODE;
        cfg_data      <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= KIND_LOAD_P;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // every subkey written before any block is ciphered
        for (int i = 0; i < BF_P_WORDS; i++)
            send_item(KIND_LOAD_P, INDEX_W'(i), $urandom(), rand_block());
        for (int i = 0; i < SBOX_COUNT * SBOX_DEPTH; i++)
            send_item(KIND_LOAD_S, INDEX_W'(i), $urandom(), rand_block());

        // directed: extreme entries and words, ignored p loads, ecb blocks
        send_item(KIND_LOAD_S, '0, '0, '0);
        send_item(KIND_LOAD_S, '1, '1, '1);
        send_item(KIND_LOAD_P, '0, '1, '0);
        send_item(KIND_LOAD_P, INDEX_W'(BF_P_WORDS - 1), '0, '1);
        send_item(KIND_LOAD_P, INDEX_W'(BF_P_WORDS), $urandom(), rand_block());
        send_item(KIND_LOAD_P, '1, $urandom(), rand_block());
        send_cipher(KIND_ENCRYPT, '0);
        send_cipher(KIND_ENCRYPT, '1);
        send_cipher(KIND_ENCRYPT, 64'h8000_0000_0000_0001);
        send_cipher(KIND_DECRYPT, '0);
        send_cipher(KIND_DECRYPT, '1);

        // directed: unused register indexes, then chaining
        write_register(CFG_SPARE_2, '1);
        write_register(CFG_SPARE_3, '1);
        write_register(CFG_MODE, '1);
        write_register(CFG_IV, '1);
        for (int i = 0; i < 3; i++) send_cipher(KIND_ENCRYPT, rand_block());
        for (int i = 0; i < 3; i++) send_cipher(KIND_DECRYPT, rand_block());
        // mode change keeps both chains
        write_register(CFG_MODE, 64'hFFFF_FFFF_FFFF_FFFE);
        send_cipher(KIND_ENCRYPT, rand_block());
        write_register(CFG_MODE, 64'h1);
        send_cipher(KIND_ENCRYPT, rand_block());
        send_cipher(KIND_DECRYPT, rand_block());
        // iv write restarts both chains
        write_register(CFG_IV, '0);
        send_cipher(KIND_ENCRYPT, rand_block());
        send_cipher(KIND_DECRYPT, rand_block());

        for (int ph = 0; ph < PHASES; ph++) begin
            cbc_phase = ph[0] || (ph == PHASES - 1);
            cfg_word  = {$urandom(), $urandom()};
            cfg_word[0] = cbc_phase;
            write_register(CFG_MODE, cfg_word);
            steady = (ph == 2);
            if (ph != 4) begin
                if (ph == 1) cfg_word = '1;
                else if (ph == 3) cfg_word = '0;
                else cfg_word = {$urandom(), $urandom()};
                write_register(CFG_IV, cfg_word);
            end
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (ph == 4 && n == 10) hold_request = 1'b1;
                pick = $urandom_range(99);
                if (pick < 10) begin
                    send_item(KIND_LOAD_S, INDEX_W'($urandom_range(1023)), $urandom(),
                              rand_block());
                end else if (pick < 14) begin
                    send_item(KIND_LOAD_P, INDEX_W'($urandom_range(BF_P_WORDS - 1)),
                              $urandom(), rand_block());
                end else if (pick < 17) begin
                    send_item(KIND_LOAD_P, INDEX_W'($urandom_range(1023, BF_P_WORDS)),
                              $urandom(), rand_block());
                end else if (pick < 60) begin
                    send_cipher(KIND_ENCRYPT, rand_block());
                end else begin
                    blk = rand_block();
                    if ($urandom_range(1) == 1 && sb.enc_log.size() != 0) blk = sb.enc_log[$];
                    send_cipher(KIND_DECRYPT, blk);
                end
            end
            // chained round trip: same iv, decrypt what was just encrypted
            if (cbc_phase) begin
                cfg_word = {$urandom(), $urandom()};
                write_register(CFG_IV, cfg_word);
                sb.enc_log.delete();
                for (int k = 0; k < ROUND_TRIP; k++) send_cipher(KIND_ENCRYPT, rand_block());
                wait_idle();
                trip = sb.enc_log;
                write_register(CFG_IV, cfg_word);
                foreach (trip[k]) send_cipher(KIND_DECRYPT, trip[k]);
            end
        end
        steady = 1'b0;

        wait_idle();
        $display("checked %0d blocks after %0d subkey loads and %0d register writes",
                 sb.blocks_checked, sb.loads_seen, sb.config_writes);
        $display("covered ecb and cbc phases, edge ivs, cbc round trips and a long output stall");
        if (sb.errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule
